### rtl/hsl2rgb_pkg.sv
package hsl2rgb_pkg;

  // Fixed-point format of the lightness / saturation fractions
  localparam int FRAC_BITS = 16;
  localparam int FW        = FRAC_BITS + 1;        // holds 0 .. 1.0 inclusive

  // Field widths
  localparam int HUE_W = 9;
  localparam int SAT_W = 8;
  localparam int LIG_W = 9;
  localparam int CH_W  = 8;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  // Repeats of the lightness / saturation code that cover FRAC_BITS bits
  localparam int LREP = (FRAC_BITS + LIG_W - 1) / LIG_W;
  localparam int SREP = (FRAC_BITS + SAT_W - 1) / SAT_W;

  // Ramp product d * m and its division by 511
  localparam int M_W         = 9;
  localparam int PW          = FW + M_W;
  localparam int DIV_SHIFT   = 9;
  localparam int DIVISOR     = (1 << DIV_SHIFT) - 1;
  localparam int DIV_STEPS   = (PW - DIV_SHIFT + 7) / 8 + 2;
  localparam int DIV_STEPS_A = DIV_STEPS / 2;
  localparam int DIV_STEPS_B = DIV_STEPS - DIV_STEPS_A;
  localparam int GREY_W      = LIG_W + CH_W;
  localparam int GREY_STEPS  = 3;

  // Hue position in units of 1/1533 turn
  localparam int HUE_POS_W = 11;
  localparam logic [HUE_POS_W-1:0] HUE_THIRD      = 11'd511;
  localparam logic [HUE_POS_W-1:0] HUE_TWO_THIRDS = 11'd1022;
  localparam logic [HUE_POS_W-1:0] SEG_RISE_END   = 11'd255;
  localparam logic [HUE_POS_W-1:0] SEG_HIGH_END   = 11'd766;

  localparam logic [LIG_W-1:0] LIG_HALF = 9'd255;

  localparam int NUM_CH   = 3;
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  typedef logic [FW-1:0] frac_t;

  localparam frac_t ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HIGH,
    SEG_FALL,
    SEG_LOW
  } seg_kind_t;

  typedef struct packed {
    seg_kind_t        kind;
    logic [M_W-1:0]   m;
  } seg_t;

  typedef struct packed {
    logic [LIG_W-1:0] lightness;
    logic [SAT_W-1:0] saturation;
    logic [HUE_W-1:0] hue;
  } hsl_t;

  typedef struct packed {
    frac_t                   v1;
    frac_t                   v2;
    frac_t                   d;
    seg_t [NUM_CH-1:0]       seg;
    logic                    grey;
    logic [CH_W-1:0]         grey_val;
  } mix_t;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } rgb_t;

  typedef struct packed {
    logic [PW-1:0] q;
    logic [PW-1:0] s;
  } div_t;

  // Fold s into q by s = 512*a + b -> q += a, s = a + b (divide by 511)
  function automatic div_t div511_fold(div_t x, int steps);
    div_t          r;
    logic [PW-1:0] hi;
    r = x;
    for (int i = 0; i < steps; i++) begin
      hi  = r.s >> DIV_SHIFT;
      r.q = r.q + hi;
      r.s = hi + PW'(r.s[DIV_SHIFT-1:0]);
    end
    return r;
  endfunction

  // Remainder folded down to 0..511; 511 stands for a zero remainder
  function automatic logic [PW-1:0] div511_done(div_t x);
    return x.q + PW'(x.s == PW'(DIVISOR));
  endfunction

endpackage

### rtl/hsl2rgb_mix.sv
module hsl2rgb_mix (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  hsl2rgb_pkg::hsl_t up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output hsl2rgb_pkg::mix_t dn_data
);
  import hsl2rgb_pkg::*;

  typedef struct packed {
    frac_t               lq;
    frac_t               sq;
    logic [2*FW-1:0]     prod;
    logic                light_hi;
    logic                grey;
    logic [GREY_W-1:0]   g;
    seg_t [NUM_CH-1:0]   seg;
  } frac_stage_t;

  function automatic seg_t hue_seg(logic [HUE_POS_W-1:0] t);
    seg_t                  r;
    logic [HUE_POS_W-1:0]  back;
    back   = HUE_TWO_THIRDS - t;
    r.m    = '0;
    r.kind = SEG_LOW;
    priority if (t <= SEG_RISE_END) begin
      r.kind = SEG_RISE;
      r.m    = {t[7:0], 1'b0};
    end else if (t <= SEG_HIGH_END) begin
      r.kind = SEG_HIGH;
    end else if (t < HUE_TWO_THIRDS) begin
      r.kind = SEG_FALL;
      r.m    = {back[7:0], 1'b0};
    end else begin
      r.kind = SEG_LOW;
    end
    return r;
  endfunction

  logic                  s0_v_r, s1_v_r;
  logic                  s0_adv, s1_adv;
  frac_stage_t           s0_r, s0_nxt;
  mix_t                  s1_r, s1_nxt;

  logic [LREP*LIG_W-1:0] lig_rep;
  logic [SREP*SAT_W-1:0] sat_rep;
  frac_t                 lq, sq;
  logic [HUE_POS_W-1:0]  t3, t_red, t_blue;

  frac_t                 ls, v1, v2;
  logic [FW:0]           v2_sum, lq2;
  div_t                  g_div;

  assign s1_adv   = ~s1_v_r | dn_ready;
  assign s0_adv   = ~s0_v_r | s1_adv;
  assign up_ready = s0_adv;
  assign dn_valid = s1_v_r;
  assign dn_data  = s1_r;

  // Stage 0: fractions, L*S product, hue segments
  always_comb begin
    // x/511 and x/255 are the code repeated as a binary fraction
    lig_rep = {LREP{up_data.lightness}};
    sat_rep = {SREP{up_data.saturation}};
    lq = (up_data.lightness == '1) ? ONE : FW'(lig_rep[LREP*LIG_W-1 -: FRAC_BITS]);
    sq = (up_data.saturation == '1) ? ONE : FW'(sat_rep[SREP*SAT_W-1 -: FRAC_BITS]);

    t3      = ({2'b00, up_data.hue} << 1) + {2'b00, up_data.hue};
    t_red   = (t3 > HUE_TWO_THIRDS) ? t3 - HUE_TWO_THIRDS : t3 + HUE_THIRD;
    t_blue  = (t3 < HUE_THIRD) ? t3 + HUE_TWO_THIRDS : t3 - HUE_THIRD;

    s0_nxt.lq       = lq;
    s0_nxt.sq       = sq;
    s0_nxt.prod     = {{FW{1'b0}}, lq} * {{FW{1'b0}}, sq};
    s0_nxt.light_hi = (up_data.lightness > LIG_HALF);
    s0_nxt.grey     = (up_data.saturation == '0);
    s0_nxt.g        = {up_data.lightness, {CH_W{1'b0}}} - GREY_W'(up_data.lightness);
    s0_nxt.seg[CH_RED]   = hue_seg(t_red);
    s0_nxt.seg[CH_GREEN] = hue_seg(t3);
    s0_nxt.seg[CH_BLUE]  = hue_seg(t_blue);
  end

  // Stage 1: v1, v2, ramp span, grey level
  always_comb begin
    ls     = s0_r.prod[FRAC_BITS +: FW];
    v2_sum = {1'b0, s0_r.lq} +
             (s0_r.light_hi ? ({1'b0, s0_r.sq} - {1'b0, ls}) : {1'b0, ls});
    v2     = (v2_sum > {1'b0, ONE}) ? ONE : v2_sum[FW-1:0];
    lq2    = {s0_r.lq, 1'b0};
    v1     = (lq2 > {1'b0, v2}) ? FW'(lq2 - {1'b0, v2}) : '0;

    g_div.q = '0;
    g_div.s = PW'(s0_r.g);

    s1_nxt.v1       = v1;
    s1_nxt.v2       = v2;
    s1_nxt.d        = (v2 > v1) ? v2 - v1 : '0;
    s1_nxt.seg      = s0_r.seg;
    s1_nxt.grey     = s0_r.grey;
    s1_nxt.grey_val = CH_W'(div511_done(div511_fold(g_div, GREY_STEPS)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
    end else begin
      if (s0_adv) s0_v_r <= up_valid;
      if (s1_adv) s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_adv) s0_r <= s0_nxt;
    if (s1_adv) s1_r <= s1_nxt;
  end

  a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> (s1_r.v2 <= ONE) && (s1_r.v1 <= s1_r.v2))
    else $error("v1/v2 out of order or above one");

  a_grey_flat: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_r.grey) |-> (s1_r.d == '0))
    else $error("zero saturation gave a nonzero ramp span");

endmodule

### rtl/hsl2rgb_ramp.sv
module hsl2rgb_ramp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  hsl2rgb_pkg::mix_t up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output hsl2rgb_pkg::rgb_t dn_data
);
  import hsl2rgb_pkg::*;

  typedef struct packed {
    div_t [NUM_CH-1:0]      x;
    frac_t                  v1;
    frac_t                  v2;
    seg_kind_t [NUM_CH-1:0] kind;
    logic                   grey;
    logic [CH_W-1:0]        grey_val;
  } div_stage_t;

  typedef struct packed {
    frac_t [NUM_CH-1:0]     c;
    logic                   grey;
    logic [CH_W-1:0]        grey_val;
  } lvl_stage_t;

  logic                          s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  logic                          s2_adv, s3_adv, s4_adv, s5_adv;
  div_stage_t                    s2_r, s2_nxt, s3_r, s3_nxt;
  lvl_stage_t                    s4_r, s4_nxt;
  rgb_t                          s5_r, s5_nxt;

  logic [NUM_CH-1:0][PW-1:0]     q4;
  logic [NUM_CH-1:0][FW+CH_W-1:0] scaled;
  logic [NUM_CH-1:0][CH_W:0]     top;
  logic [NUM_CH-1:0][CH_W-1:0]   lvl;

  assign s5_adv   = ~s5_v_r | dn_ready;
  assign s4_adv   = ~s4_v_r | s5_adv;
  assign s3_adv   = ~s3_v_r | s4_adv;
  assign s2_adv   = ~s2_v_r | s3_adv;
  assign up_ready = s2_adv;
  assign dn_valid = s5_v_r;
  assign dn_data  = s5_r;

  // Stage 2: d * m per channel
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      s2_nxt.x[ch].q  = '0;
      s2_nxt.x[ch].s  = PW'(up_data.d) * PW'(up_data.seg[ch].m);
      s2_nxt.kind[ch] = up_data.seg[ch].kind;
    end
    s2_nxt.v1       = up_data.v1;
    s2_nxt.v2       = up_data.v2;
    s2_nxt.grey     = up_data.grey;
    s2_nxt.grey_val = up_data.grey_val;
  end

  // Stage 3: first half of the divide by 511
  always_comb begin
    s3_nxt = s2_r;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      s3_nxt.x[ch] = div511_fold(s2_r.x[ch], DIV_STEPS_A);
    end
  end

  // Stage 4: finish the divide, pick the ramp level
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      q4[ch] = div511_done(div511_fold(s3_r.x[ch], DIV_STEPS_B));
      unique case (s3_r.kind[ch])
        SEG_RISE, SEG_FALL: s4_nxt.c[ch] = s3_r.v1 + q4[ch][FW-1:0];
        SEG_HIGH:           s4_nxt.c[ch] = s3_r.v2;
        SEG_LOW:            s4_nxt.c[ch] = s3_r.v1;
        default:            s4_nxt.c[ch] = s3_r.v1;
      endcase
    end
    s4_nxt.grey     = s3_r.grey;
    s4_nxt.grey_val = s3_r.grey_val;
  end

  // Stage 5: scale by 255, truncate, saturate; grey pixels take the grey level
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      scaled[ch] = {s4_r.c[ch], {CH_W{1'b0}}} - (FW+CH_W)'(s4_r.c[ch]);
      top[ch]    = scaled[ch][FRAC_BITS +: CH_W+1];
      lvl[ch]    = top[ch][CH_W] ? '1 : top[ch][CH_W-1:0];
      if (s4_r.grey) lvl[ch] = s4_r.grey_val;
    end
    s5_nxt.red   = lvl[CH_RED];
    s5_nxt.green = lvl[CH_GREEN];
    s5_nxt.blue  = lvl[CH_BLUE];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else begin
      if (s2_adv) s2_v_r <= up_valid;
      if (s3_adv) s3_v_r <= s2_v_r;
      if (s4_adv) s4_v_r <= s3_v_r;
      if (s5_adv) s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) s2_r <= s2_nxt;
    if (s3_adv) s3_r <= s3_nxt;
    if (s4_adv) s4_r <= s4_nxt;
    if (s5_adv) s5_r <= s5_nxt;
  end

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r |-> (s4_r.c[CH_RED] <= ONE) && (s4_r.c[CH_GREEN] <= ONE) &&
               (s4_r.c[CH_BLUE] <= ONE))
    else $error("ramp level above one");

  a_grey_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_v_r && s4_r.grey && s5_adv) |=>
      (s5_r.red == s5_r.green) && (s5_r.green == s5_r.blue))
    else $error("grey pixel with unequal channels");

endmodule

### rtl/hsl2rgb_skid.sv
module hsl2rgb_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  hsl2rgb_pkg::rgb_t up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output hsl2rgb_pkg::rgb_t dn_data
);
  import hsl2rgb_pkg::*;

  logic out_v_r, out_v_nxt;
  logic skid_v_r, skid_v_nxt;
  rgb_t out_r, skid_r;
  logic load_from_up, load_from_skid, load_skid;

  assign up_ready = ~skid_v_r;
  assign dn_valid = out_v_r;
  assign dn_data  = out_r;

  always_comb begin
    out_v_nxt      = out_v_r;
    skid_v_nxt     = skid_v_r;
    load_from_up   = 1'b0;
    load_from_skid = 1'b0;
    load_skid      = 1'b0;
    priority if (~out_v_r | dn_ready) begin
      if (skid_v_r) begin
        // drain the parked transfer first
        load_from_skid = 1'b1;
        out_v_nxt      = 1'b1;
        skid_v_nxt     = 1'b0;
      end else begin
        load_from_up = up_valid;
        out_v_nxt    = up_valid;
      end
    end else if (up_valid & ~skid_v_r) begin
      // output stalled: park the incoming transfer
      load_skid  = 1'b1;
      skid_v_nxt = 1'b1;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_from_skid)    out_r <= skid_r;
    else if (load_from_up) out_r <= up_data;
    if (load_skid)         skid_r <= up_data;
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid slot full while output slot empty");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && dn_ready) |=> out_v_r && !skid_v_r && (out_r == $past(skid_r)))
    else $error("parked transfer lost or altered");

endmodule

### rtl/hsl_to_rgb_converter_unit.sv
// HSL to RGB pixel converter.
//
// Input stream: one pixel per transfer on in_tvalid/in_tready, with hue,
// saturation and lightness packed into in_tdata. Output stream: one RGB
// pixel per input pixel on out_tvalid/out_tready, in input order.
//
// Throughput: one pixel per cycle while out_tready stays high, through a
// six-register pipeline (fractions and L*S multiply, v1/v2, ramp
// multiply, two divide-by-511 steps, 255 scale) and a two-entry output
// buffer; an accepted pixel passes these registers in that order.
//
// Reset (rst_n low at a clock edge) empties every pipeline stage and the
// output buffer; payload registers keep stale data that is never shown.
// When out_tready is low the output buffer parks one more pixel, the
// pipeline closes its bubbles and then holds; in_tready falls only once
// every stage is full. No pixel is dropped or repeated.
module hsl_to_rgb_converter_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [8:0] hue, [16:9] saturation, [25:17] lightness, [31:26] zero
  input  logic [hsl2rgb_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] red, [15:8] green, [23:16] blue
  output logic [hsl2rgb_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import hsl2rgb_pkg::*;

  hsl_t pix_in;
  mix_t mix;
  rgb_t rgb_pipe, rgb_out;
  logic mix_valid, mix_ready;
  logic pipe_valid, pipe_ready;

  assign pix_in.hue        = in_tdata[8:0];
  assign pix_in.saturation = in_tdata[16:9];
  assign pix_in.lightness  = in_tdata[25:17];

  hsl2rgb_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_data  (pix_in),
    .dn_valid (mix_valid),
    .dn_ready (mix_ready),
    .dn_data  (mix)
  );

  hsl2rgb_ramp u_ramp (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mix_valid),
    .up_ready (mix_ready),
    .up_data  (mix),
    .dn_valid (pipe_valid),
    .dn_ready (pipe_ready),
    .dn_data  (rgb_pipe)
  );

  hsl2rgb_skid u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (pipe_valid),
    .up_ready (pipe_ready),
    .up_data  (rgb_pipe),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_data  (rgb_out)
  );

  assign out_tdata = {rgb_out.blue, rgb_out.green, rgb_out.red};

endmodule
